// ===== sv/scc_pkg.sv =====
package scc_pkg;

  // Stack geometry and word size.
  localparam int STACK_DEPTH = 64;
  localparam int WORD_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(WORD_WIDTH);

  // Fixed port field widths.
  localparam int KIND_W    = 3;
  localparam int OPERAND_W = 32;
  localparam int OUT_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int LEVEL_W   = 7;

  // Command codes carried by the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 3'd0,
    KIND_ADD  = 3'd1,
    KIND_SUB  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_DIV  = 3'd4,
    KIND_OUT  = 3'd5
  } kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMIT  = 3'd1,
    ST_DIVZ  = 3'd2,
    ST_UNDER = 3'd3,
    ST_OVER  = 3'd4
  } status_e;

  // How the stack count moves when a command finishes.
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC1 = 2'd2,
    CNT_DEC2 = 2'd3
  } cnt_op_e;

  // Source of the word written back to the stack.
  typedef enum logic [1:0] {
    WR_OPERAND = 2'd0,
    WR_ALU     = 2'd1,
    WR_QUOT    = 2'd2
  } wr_src_e;

  // Which stack entry a read fetches.
  typedef enum logic {
    RD_TOP    = 1'b0,
    RD_SECOND = 1'b1
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    lat_rhs;
    logic    lat_lhs;
    logic    div_start;
    logic    wr_en;
    wr_src_e wr_src;
    kind_e   alu_op;
    cnt_op_e cnt_op;
    logic    finish;
    status_e fin_status;
    logic    emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic lt2;
    logic empty;
    logic rhs_zero;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== sv/scc_ram.sv =====
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/scc_div.sv =====
module scc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [scc_pkg::WORD_WIDTH-1:0] dividend_i,
  input  logic [scc_pkg::WORD_WIDTH-1:0] divisor_i,
  output logic [scc_pkg::WORD_WIDTH-1:0] quotient_o,
  output logic                           done_o
);

  localparam int W = scc_pkg::WORD_WIDTH;

  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [scc_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           neg_q, neg_d;
  logic [W-1:0]                   rem_q, rem_d;
  logic [W-1:0]                   quo_q, quo_d;
  logic [W-1:0]                   dvs_q, dvs_d;
  logic [W+1:0]                   diff;
  logic                           ge;
  logic [W-1:0]                   mag_a;
  logic [W-1:0]                   mag_b;

  // Magnitudes of the signed operands; the most negative value maps onto itself.
  assign mag_a = dividend_i[W-1] ? (~dividend_i + W'(1)) : dividend_i;
  assign mag_b = divisor_i[W-1]  ? (~divisor_i + W'(1))  : divisor_i;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  assign diff = {1'b0, rem_q, quo_q[W-1]} - {2'b00, dvs_q};
  assign ge   = ~diff[W+1];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      neg_d = dividend_i[W-1] ^ divisor_i[W-1];
      rem_d = '0;
      quo_d = mag_a;
      dvs_d = mag_b;
    end else if (run_q) begin
      rem_d = ge ? diff[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q + scc_pkg::DIV_CNT_W'(1);
      if (cnt_q == scc_pkg::DIV_CNT_W'(W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flags are reset; the working words need none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  // Apply the sign; this wraps for the most negative value divided by minus one.
  assign quotient_o = neg_q ? (~quo_q + W'(1)) : quo_q;
  assign done_o     = done_q;

endmodule

// ===== sv/scc_datapath.sv =====
module scc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scc_pkg::dp_cmd_t                  cmd_i,
  output scc_pkg::dp_stat_t                 stat_o,
  input  logic signed [scc_pkg::OPERAND_W-1:0] operand_i,
  output logic                              done_o,
  output logic signed [scc_pkg::OUT_W-1:0]  out_value_o,
  output logic [scc_pkg::STATUS_W-1:0]      status_o,
  output logic [scc_pkg::LEVEL_W-1:0]       stack_level_o
);

  localparam int W = scc_pkg::WORD_WIDTH;

  logic [scc_pkg::CNT_W-1:0]  count_q, count_d;
  logic [scc_pkg::CNT_W-1:0]  top_idx;
  logic [scc_pkg::CNT_W-1:0]  second_idx;
  logic [scc_pkg::ADDR_W-1:0] rd_addr;
  logic [scc_pkg::ADDR_W-1:0] wr_addr;
  logic [W-1:0]               wr_data;
  logic [W-1:0]               rdata;
  logic [W-1:0]               rhs_q;
  logic [W-1:0]               lhs_q;
  logic [W-1:0]               alu_res;
  logic [W-1:0]               quotient;
  logic                       div_done;
  logic                       done_q;
  logic [scc_pkg::OUT_W-1:0]  out_value_q;
  logic [scc_pkg::STATUS_W-1:0] status_q;
  logic [scc_pkg::LEVEL_W-1:0]  level_q;

  // Stack addressing relative to the current count.
  assign top_idx    = count_q - scc_pkg::CNT_W'(1);
  assign second_idx = count_q - scc_pkg::CNT_W'(2);
  assign rd_addr    = (cmd_i.rd_sel == scc_pkg::RD_TOP) ? top_idx[scc_pkg::ADDR_W-1:0]
                                                       : second_idx[scc_pkg::ADDR_W-1:0];
  assign wr_addr    = (cmd_i.wr_src == scc_pkg::WR_OPERAND) ? count_q[scc_pkg::ADDR_W-1:0]
                                                            : second_idx[scc_pkg::ADDR_W-1:0];

  // Add, subtract and multiply, all wrapping at the word width.
  always_comb begin
    case (cmd_i.alu_op)
      scc_pkg::KIND_ADD: alu_res = lhs_q + rhs_q;
      scc_pkg::KIND_SUB: alu_res = lhs_q - rhs_q;
      scc_pkg::KIND_MUL: alu_res = lhs_q * rhs_q;
      default:           alu_res = lhs_q + rhs_q;
    endcase
  end

  // Select the word written back to the stack.
  always_comb begin
    case (cmd_i.wr_src)
      scc_pkg::WR_OPERAND: wr_data = W'(operand_i);
      scc_pkg::WR_ALU:     wr_data = alu_res;
      scc_pkg::WR_QUOT:    wr_data = quotient;
      default:             wr_data = alu_res;
    endcase
  end

  // Next stack count.
  always_comb begin
    case (cmd_i.cnt_op)
      scc_pkg::CNT_INC:  count_d = count_q + scc_pkg::CNT_W'(1);
      scc_pkg::CNT_DEC1: count_d = count_q - scc_pkg::CNT_W'(1);
      scc_pkg::CNT_DEC2: count_d = count_q - scc_pkg::CNT_W'(2);
      default:           count_d = count_q;
    endcase
  end

  scc_ram #(
    .WIDTH(W),
    .DEPTH(scc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // The divisor comes from the latched top entry and the dividend straight off the read port.
  scc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rdata),
    .divisor_i  (rhs_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // Operand latches.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_rhs) begin
      rhs_q <= rdata;
    end
    if (cmd_i.lat_lhs) begin
      lhs_q <= rdata;
    end
  end

  // Stack count and the strobe are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.finish;
    end
  end

  // Result registers, loaded when a command finishes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_value_q <= cmd_i.emit ? scc_pkg::OUT_W'(signed'(rdata)) : '0;
      status_q    <= cmd_i.fin_status;
      level_q     <= scc_pkg::LEVEL_W'(count_d);
    end
  end

  assign stat_o.full     = (count_q == scc_pkg::CNT_W'(scc_pkg::STACK_DEPTH));
  assign stat_o.lt2      = (count_q < scc_pkg::CNT_W'(2));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.rhs_zero = (rhs_q == '0);
  assign stat_o.div_done = div_done;

  assign done_o        = done_q;
  assign out_value_o   = out_value_q;
  assign status_o      = status_q;
  assign stack_level_o = level_q;

endmodule

// ===== sv/scc_ctrl.sv =====
module scc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [scc_pkg::KIND_W-1:0]   kind_i,
  output logic                         busy_o,
  output scc_pkg::dp_cmd_t             cmd_o,
  input  scc_pkg::dp_stat_t            stat_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RD_RHS = 6'b000010,
    S_RD_LHS = 6'b000100,
    S_ALU    = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  scc_pkg::kind_e  kind_q, kind_d;
  scc_pkg::kind_e  kind_in;

  assign kind_in = scc_pkg::kind_e'(kind_i);
  assign busy_o  = (state_q != S_IDLE);

  // Sequencing of one command; the datapath acts on the command word.
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    cmd_o        = '0;
    cmd_o.alu_op = kind_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d = kind_in;
          case (kind_in)
            scc_pkg::KIND_PUSH: begin
              cmd_o.finish = 1'b1;
              if (stat_i.full) begin
                cmd_o.fin_status = scc_pkg::ST_OVER;
              end else begin
                cmd_o.wr_en      = 1'b1;
                cmd_o.wr_src     = scc_pkg::WR_OPERAND;
                cmd_o.cnt_op     = scc_pkg::CNT_INC;
                cmd_o.fin_status = scc_pkg::ST_OK;
              end
            end
            scc_pkg::KIND_ADD, scc_pkg::KIND_SUB, scc_pkg::KIND_MUL,
            scc_pkg::KIND_DIV: begin
              if (stat_i.lt2) begin
                cmd_o.finish     = 1'b1;
                cmd_o.fin_status = scc_pkg::ST_UNDER;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = scc_pkg::RD_TOP;
                state_d      = S_RD_RHS;
              end
            end
            scc_pkg::KIND_OUT: begin
              if (stat_i.empty) begin
                cmd_o.finish     = 1'b1;
                cmd_o.fin_status = scc_pkg::ST_UNDER;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = scc_pkg::RD_TOP;
                state_d      = S_OUT;
              end
            end
            default: begin
              // Unused command codes complete with no effect.
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = scc_pkg::ST_OK;
            end
          endcase
        end
      end
      S_RD_RHS: begin
        cmd_o.lat_rhs = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = scc_pkg::RD_SECOND;
        state_d       = S_RD_LHS;
      end
      S_RD_LHS: begin
        cmd_o.lat_lhs = 1'b1;
        if (kind_q == scc_pkg::KIND_DIV) begin
          if (stat_i.rhs_zero) begin
            cmd_o.cnt_op     = scc_pkg::CNT_DEC2;
            cmd_o.finish     = 1'b1;
            cmd_o.fin_status = scc_pkg::ST_DIVZ;
            state_d          = S_IDLE;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          state_d = S_ALU;
        end
      end
      S_ALU: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_src     = scc_pkg::WR_ALU;
        cmd_o.cnt_op     = scc_pkg::CNT_DEC1;
        cmd_o.finish     = 1'b1;
        cmd_o.fin_status = scc_pkg::ST_OK;
        state_d          = S_IDLE;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_src     = scc_pkg::WR_QUOT;
          cmd_o.cnt_op     = scc_pkg::CNT_DEC1;
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = scc_pkg::ST_OK;
          state_d          = S_IDLE;
        end
      end
      S_OUT: begin
        cmd_o.emit       = 1'b1;
        cmd_o.cnt_op     = scc_pkg::CNT_DEC1;
        cmd_o.finish     = 1'b1;
        cmd_o.fin_status = scc_pkg::ST_EMIT;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= scc_pkg::KIND_PUSH;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== sv/stack_calculator_core_top.sv =====
// Reverse-Polish stack calculator on a 64-entry stack of signed 32-bit words held in a
// single-port-read RAM. A command is taken when start_i is high while busy_o is low, and
// exactly one result follows: done_o is high for a single cycle with out_value_o, status_o
// and stack_level_o valid, and the receiver cannot hold that transfer off, so it must take
// the result in that cycle. Push, unused codes and commands that fail on under- or overflow
// finish straight from idle, out after one stack read, add, sub and mul after two reads
// through the one RAM read port and then the ALU, a divide by zero after those reads, and a
// divide once the restoring divider (one quotient bit per cycle) is done. busy_o is low
// again in the cycle that carries the strobe, so a new command may be started there.
module stack_calculator_core_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [scc_pkg::KIND_W-1:0]           kind_i,
  input  logic signed [scc_pkg::OPERAND_W-1:0] operand_i,
  output logic                                 done_o,
  output logic signed [scc_pkg::OUT_W-1:0]     out_value_o,
  output logic [scc_pkg::STATUS_W-1:0]         status_o,
  output logic [scc_pkg::LEVEL_W-1:0]          stack_level_o
);

  scc_pkg::dp_cmd_t  cmd;
  scc_pkg::dp_stat_t stat;

  scc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  scc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operand_i     (operand_i),
    .done_o        (done_o),
    .out_value_o   (out_value_o),
    .status_o      (status_o),
    .stack_level_o (stack_level_o)
  );

endmodule

// ===== tb/sv/stack_calculator_core_top_tb.sv =====
`timescale 1ns / 1ps

module stack_calculator_core_top_tb;

  // Codes 6 and 7 are not commands; the block must treat them as no-ops.
  localparam logic [scc_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [scc_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;

  localparam int unsigned NUM_COMMANDS = 1300;
  localparam int unsigned MAX_GAP      = 16;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned MAX_PRINTED  = 100;

  typedef struct {
    logic [scc_pkg::KIND_W-1:0]    kind;
    logic [scc_pkg::OPERAND_W-1:0] operand;
    int unsigned                   gap;
  } cmd_item_t;

  typedef struct {
    logic signed [scc_pkg::OUT_W-1:0] out_value;
    scc_pkg::status_e                 status;
    logic [scc_pkg::LEVEL_W-1:0]      level;
  } calc_result_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [scc_pkg::KIND_W-1:0]           kind_i = '0;
  logic signed [scc_pkg::OPERAND_W-1:0] operand_i = '0;
  logic                                 done_o;
  logic signed [scc_pkg::OUT_W-1:0]     out_value_o;
  logic [scc_pkg::STATUS_W-1:0]         status_o;
  logic [scc_pkg::LEVEL_W-1:0]          stack_level_o;

  // Commands waiting to be driven and results waiting to arrive.
  cmd_item_t    pending_cmds[$];
  calc_result_t expected_results[$];

  // Shadow copy of the operand stack.
  logic [scc_pkg::WORD_WIDTH-1:0] shadow_stack[scc_pkg::STACK_DEPTH];
  int unsigned                    shadow_count = 0;

  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned queued_cmds = 0;
  bit          no_gaps = 1'b0;
  logic        took_q = 1'b0;
  cmd_item_t   drv_item;

  stack_calculator_core_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .operand_i     (operand_i),
    .done_o        (done_o),
    .out_value_o   (out_value_o),
    .status_o      (status_o),
    .stack_level_o (stack_level_o)
  );

  always #5 clk_i = ~clk_i;

  // Print one line per mismatch, up to a cap, and count every one.
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("MISMATCH at cycle %0d: %s", cycle_cnt, what);
    end
  endtask

  // Execute one command on the shadow stack and return the result it causes.
  function automatic calc_result_t execute_command(
      input logic [scc_pkg::KIND_W-1:0] cmd,
      input logic [scc_pkg::WORD_WIDTH-1:0] value);
    calc_result_t                   res;
    logic [scc_pkg::WORD_WIDTH-1:0] rhs;
    logic [scc_pkg::WORD_WIDTH-1:0] lhs;
    logic [scc_pkg::WORD_WIDTH-1:0] word;
    logic [scc_pkg::WORD_WIDTH-1:0] mag_l;
    logic [scc_pkg::WORD_WIDTH-1:0] mag_r;
    res.out_value = '0;
    res.status    = scc_pkg::ST_OK;
    word          = '0;
    case (cmd)
      scc_pkg::KIND_PUSH: begin
        if (shadow_count >= scc_pkg::STACK_DEPTH) begin
          res.status = scc_pkg::ST_OVER;
        end else begin
          shadow_stack[shadow_count] = value;
          shadow_count++;
        end
      end
      scc_pkg::KIND_ADD, scc_pkg::KIND_SUB, scc_pkg::KIND_MUL, scc_pkg::KIND_DIV: begin
        if (shadow_count < 2) begin
          res.status = scc_pkg::ST_UNDER;
        end else begin
          rhs = shadow_stack[shadow_count-1];
          lhs = shadow_stack[shadow_count-2];
          shadow_count -= 2;
          case (cmd)
            scc_pkg::KIND_ADD: word = lhs + rhs;
            scc_pkg::KIND_SUB: word = lhs - rhs;
            scc_pkg::KIND_MUL: word = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                res.status = scc_pkg::ST_DIVZ;
              end else begin
                // Divide magnitudes, then fix the sign; min / -1 wraps to min.
                mag_l = lhs[scc_pkg::WORD_WIDTH-1] ? (~lhs + 1'b1) : lhs;
                mag_r = rhs[scc_pkg::WORD_WIDTH-1] ? (~rhs + 1'b1) : rhs;
                word  = mag_l / mag_r;
                if (lhs[scc_pkg::WORD_WIDTH-1] ^ rhs[scc_pkg::WORD_WIDTH-1]) begin
                  word = ~word + 1'b1;
                end
              end
            end
          endcase
          if (res.status == scc_pkg::ST_OK) begin
            shadow_stack[shadow_count] = word;
            shadow_count++;
          end
        end
      end
      scc_pkg::KIND_OUT: begin
        if (shadow_count == 0) begin
          res.status = scc_pkg::ST_UNDER;
        end else begin
          shadow_count--;
          res.out_value = shadow_stack[shadow_count];
          res.status    = scc_pkg::ST_EMIT;
        end
      end
      default: ;
    endcase
    res.level = shadow_count[scc_pkg::LEVEL_W-1:0];
    return res;
  endfunction

  // Operand values: often small so that divides by zero happen, some extremes, the rest random.
  function automatic logic [scc_pkg::OPERAND_W-1:0] random_word();
    int s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        s = $urandom_range(0, 40);
        return s - 20;
      end
      4: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic [scc_pkg::KIND_W-1:0] k,
                          input logic [scc_pkg::OPERAND_W-1:0] v);
    cmd_item_t item;
    item.kind    = k;
    item.operand = v;
    item.gap     = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    pending_cmds.push_back(item);
    if (k <= scc_pkg::KIND_OUT) begin
      queued_cmds++;
    end
  endtask

  // Driver: present the next command at the falling edge once the previous
  // transfer has happened and its idle gap has run out.
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !took_q)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        drv_item = pending_cmds.pop_front();
        start     <= 1'b1;
        kind_i    <= drv_item.kind;
        operand_i <= drv_item.operand;
        gap_left  = (pending_cmds.size() > 0) ? pending_cmds[0].gap : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check an arriving result first, then predict for a new transfer
  // taken at the same edge.
  always @(posedge clk_i) begin
    calc_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result strobe with no command outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_value_o !== want.out_value) begin
            report_mismatch($sformatf("out_value got %0d expected %0d",
                                      out_value_o, want.out_value));
          end
          if (status_o !== want.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      status_o, want.status));
          end
          if (stack_level_o !== want.level) begin
            report_mismatch($sformatf("stack_level got %0d expected %0d",
                                      stack_level_o, want.level));
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(execute_command(kind_i, operand_i));
      end
    end
    took_q <= rst_ni && start && !busy;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("stack_calculator_core_top test failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned est;
    int unsigned len;
    int unsigned r;
    logic [scc_pkg::KIND_W-1:0] k;

    // Directed: empty-stack underflow, wrap, min / -1, zero divisor, spare codes.
    add_item(scc_pkg::KIND_OUT, 32'h0);
    add_item(scc_pkg::KIND_ADD, 32'h0);
    add_item(scc_pkg::KIND_PUSH, 32'h7fff_ffff);
    add_item(scc_pkg::KIND_DIV, 32'h0);
    add_item(scc_pkg::KIND_PUSH, 32'h0000_0001);
    add_item(scc_pkg::KIND_ADD, 32'hffff_ffff);
    add_item(scc_pkg::KIND_PUSH, 32'hffff_ffff);
    add_item(scc_pkg::KIND_DIV, 32'h0);
    add_item(scc_pkg::KIND_PUSH, 32'h0000_0000);
    add_item(scc_pkg::KIND_DIV, 32'h0);
    add_item(scc_pkg::KIND_PUSH, 32'h8000_0000);
    add_item(scc_pkg::KIND_PUSH, 32'h7fff_ffff);
    add_item(scc_pkg::KIND_SUB, 32'h0);
    add_item(scc_pkg::KIND_PUSH, 32'h7fff_ffff);
    add_item(scc_pkg::KIND_MUL, 32'h0);
    add_item(scc_pkg::KIND_PUSH, 32'hffff_fff9);
    add_item(scc_pkg::KIND_PUSH, 32'h0000_0002);
    add_item(scc_pkg::KIND_DIV, 32'h0);
    add_item(scc_pkg::KIND_SUB, 32'h0);
    add_item(KIND_SPARE6, 32'h0);
    add_item(KIND_SPARE7, 32'hffff_ffff);
    add_item(scc_pkg::KIND_OUT, 32'h0);
    add_item(scc_pkg::KIND_OUT, 32'h0);

    // Random episodes; est tracks the level, ignoring zero divisors, so it
    // is never more than one below the real level.
    est = 0;
    r   = 0;
    while (queued_cmds < NUM_COMMANDS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (r == 0 || $urandom_range(0, 39) == 0) begin
        // Fill to overflow after emptying the stack, then drain it again.
        repeat (est + 2) add_item(scc_pkg::KIND_OUT, random_word());
        repeat (scc_pkg::STACK_DEPTH + $urandom_range(1, 4)) begin
          add_item(scc_pkg::KIND_PUSH, random_word());
        end
        est = scc_pkg::STACK_DEPTH;
        while (est > 0) begin
          if (est >= 2 && $urandom_range(0, 1) == 0) begin
            add_item(logic'($urandom_range(1, 4)) ?
                       scc_pkg::KIND_W'($urandom_range(1, 4)) : scc_pkg::KIND_ADD,
                     random_word());
          end else begin
            add_item(scc_pkg::KIND_OUT, random_word());
          end
          est--;
        end
        add_item(scc_pkg::KIND_OUT, random_word());
      end else if ($urandom_range(0, 9) == 0) begin
        // Noise: any code, any operand.
        repeat ($urandom_range(1, 4)) begin
          k = scc_pkg::KIND_W'($urandom_range(0, 7));
          add_item(k, $urandom);
          if (k == scc_pkg::KIND_PUSH && est < scc_pkg::STACK_DEPTH) begin
            est++;
          end else if ((k == scc_pkg::KIND_OUT ||
                        (k >= scc_pkg::KIND_ADD && k <= scc_pkg::KIND_DIV)) && est > 0) begin
            est--;
          end
        end
      end else begin
        // Well-formed expression with random content, now and then broken.
        len = $urandom_range(3, 14);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (est < 2 && r >= 10) begin
            add_item(scc_pkg::KIND_PUSH, random_word());
            est++;
          end else if (est < 16 && r < 30) begin
            add_item(scc_pkg::KIND_PUSH, random_word());
            est++;
          end else if (r < 85) begin
            add_item(scc_pkg::KIND_W'($urandom_range(1, 4)), random_word());
            if (est > 0) est--;
          end else begin
            add_item(scc_pkg::KIND_OUT, random_word());
            if (est > 0) est--;
          end
        end
        add_item(scc_pkg::KIND_OUT, random_word());
        if (est > 0) est--;
      end
      r = 1;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() > 0 || start) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("stack_calculator_core_top test passed");
    end else begin
      $display("stack_calculator_core_top test failed");
    end
    $finish;
  end

endmodule
